[sv/ith_pkg.sv]
// ----------------------------------------------------------------------------
// ith_pkg
// shared widths, segment codes and the elaboration-time log2 helper for the
// iteration count to hue wheel color pipeline
// ----------------------------------------------------------------------------
package ith_pkg;

	// fixed field widths
	localparam int IN_W    = 31;
	localparam int COLOR_W = 8;
	localparam int EXP_W   = 5;
	localparam int MANT_W  = 31;

	// default configuration
	localparam int SEGMENT_STEPS_DEF = 60;
	localparam int LOG_FRAC_BITS_DEF = 20;

	localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [COLOR_W-1:0] CHAN_FULL    = 8'hFF;
	localparam logic [COLOR_W-1:0] CHAN_OFF     = 8'h00;

	// hue wheel segments, in wheel order
	typedef enum logic [2:0] {
		SEG_RED_YEL = 3'd0,
		SEG_YEL_GRN = 3'd1,
		SEG_GRN_CYN = 3'd2,
		SEG_CYN_BLU = 3'd3,
		SEG_BLU_MAG = 3'd4,
		SEG_MAG_RED = 3'd5
	} seg_t;

	// fixed point log2 by repeated squaring, for constants only
	function automatic logic [63:0] fixed_log2(input logic [63:0] n, input int frac_bits);
		logic [63:0] e;
		logic [63:0] m;
		logic [63:0] frac;
		logic [63:0] sq;
		e    = '0;
		frac = '0;
		for (int i = 0; i < 30; i++) begin
			if ((n >> (i + 1)) != 0) begin
				e = 64'(i + 1);
			end
		end
		m = n << (64'd30 - e);
		for (int k = 0; k < frac_bits; k++) begin
			sq   = m * m;
			frac = frac << 1;
			if (sq >= (64'd1 << 61)) begin
				frac = frac | 64'd1;
				m    = sq >> 31;
			end else begin
				m = sq >> 30;
			end
		end
		return (e << frac_bits) + frac;
	endfunction

endpackage

[sv/iteration_to_hue_color.sv]
// a request passes the log2 unit, then stages s1 to s4 and the output register s5
// throughput: one request per cycle while the result side does not stall; the log2
//   squaring chain, one 31 x 31 square per stage, sets the depth of the pipeline
// a stalled result holds in the output register; empty stages keep filling
// reset clears the stage valid bits only; no clearing pass, no other state
// ----------------------------------------------------------------------------
// iteration_to_hue_color
// maps an escape iteration count to an opaque color on a six segment hue
// wheel with smootherstep ramps; large counts use a log2 scale
// ----------------------------------------------------------------------------
module iteration_to_hue_color
	import ith_pkg::*;
#(
	parameter int SEGMENT_STEPS = SEGMENT_STEPS_DEF,
	parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] iteration_count, [31] zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
);

	localparam int WHEEL   = 6 * SEGMENT_STEPS;
	localparam int IDX_W   = $clog2(WHEEL);
	localparam int WHEEL_W = $clog2(WHEEL + 1);
	localparam int POS_W   = $clog2(SEGMENT_STEPS);
	localparam int DIFF_W  = EXP_W + LOG_FRAC_BITS;
	localparam int PROD_W  = DIFF_W + WHEEL_W;
	localparam int FULL_W  = EXP_W + WHEEL_W;
	localparam int TAG_W   = IDX_W + 1;

	localparam logic [DIFF_W-1:0]  LOG_WHEEL = DIFF_W'(fixed_log2(64'(WHEEL), LOG_FRAC_BITS));
	localparam logic [WHEEL_W-1:0] WHEEL_C   = WHEEL_W'(WHEEL);
	localparam logic [FULL_W-1:0]  WHEEL_F   = FULL_W'(WHEEL);
	localparam logic [IDX_W:0]     SEG_X4    = (IDX_W+1)'(4 * SEGMENT_STEPS);
	localparam logic [IDX_W:0]     SEG_X2    = (IDX_W+1)'(2 * SEGMENT_STEPS);
	localparam logic [IDX_W:0]     SEG_X1    = (IDX_W+1)'(SEGMENT_STEPS);
	localparam logic [63:0]        S64       = 64'(SEGMENT_STEPS);
	localparam logic [63:0]        DEN       = S64 * S64 * S64 * S64 * S64;

	// ramp rom, truncated 255 * smootherstep(p / SEGMENT_STEPS)
	logic [COLOR_W-1:0] ramp_up [SEGMENT_STEPS];
	logic [COLOR_W-1:0] ramp_dn [SEGMENT_STEPS];

	genvar p;
	generate
		for (p = 0; p < SEGMENT_STEPS; p++) begin : g_rom
			localparam logic [63:0] P64  = 64'(p);
			localparam logic [63:0] NUM  =
				P64 * P64 * P64 * (64'd10 * S64 * S64 + 64'd6 * P64 * P64 - 64'd15 * P64 * S64);
			localparam logic [63:0] NUMC = (NUM > DEN) ? DEN : NUM;
			localparam logic [63:0] UPV  = (64'd255 * NUMC) / DEN;
			localparam logic [63:0] DNV  = (64'd255 * (DEN - NUMC)) / DEN;
			assign ramp_up[p] = COLOR_W'(UPV);
			assign ramp_dn[p] = COLOR_W'(DNV);
		end
	endgenerate

	// input side: small counts index the wheel directly
	logic [IN_W-1:0]  count_in;
	logic [TAG_W-1:0] tag_in;

	assign count_in = s_tdata[IN_W-1:0];
	assign tag_in   = {(count_in < IN_W'(WHEEL)), count_in[IDX_W-1:0]};

	// log2 unit
	logic                     lg_valid;
	logic                     lg_ready;
	logic [EXP_W-1:0]         lg_exp;
	logic [LOG_FRAC_BITS-1:0] lg_frac;
	logic [TAG_W-1:0]         lg_tag;

	ith_log2 #(
		.LOG_FRAC_BITS(LOG_FRAC_BITS),
		.TAG_W        (TAG_W)
	) u_log2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_count (count_in),
		.in_tag   (tag_in),
		.out_valid(lg_valid),
		.out_ready(lg_ready),
		.out_exp  (lg_exp),
		.out_frac (lg_frac),
		.out_tag  (lg_tag)
	);

	// stage registers
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic [DIFF_W-1:0]  diff_s1;
	logic               small_s1;
	logic [IDX_W-1:0]   nlow_s1;
	logic [FULL_W-1:0]  full_s2;
	logic [IDX_W-1:0]   idx_s3;
	seg_t               seg_s4;
	logic [POS_W-1:0]   pos_s4;
	logic [COLOR_W-1:0] red_s5, green_s5, blue_s5;

	assign rdy5     = !vld_s5 || m_tready;
	assign rdy4     = !vld_s4 || rdy5;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign lg_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= lg_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	// log difference against log2(wheel), clamped at zero
	logic [DIFF_W-1:0] ln_full;

	assign ln_full = {lg_exp, lg_frac};

	always_ff @(posedge clk) begin
		if (lg_valid && rdy1) begin
			diff_s1  <= (ln_full > LOG_WHEEL) ? (ln_full - LOG_WHEEL) : '0;
			small_s1 <= lg_tag[TAG_W-1];
			nlow_s1  <= lg_tag[IDX_W-1:0];
		end
	end

	// scale to wheel steps
	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(WHEEL_C) * PROD_W'(diff_s1);

	always_ff @(posedge clk) begin
		if (vld_s1 && rdy2) begin
			full_s2 <= small_s1 ? FULL_W'(nlow_s1) : FULL_W'(prod >> LOG_FRAC_BITS);
		end
	end

	// reduce mod wheel, value stays below 32 turns
	logic [FULL_W-1:0] red_mod;

	always_comb begin
		red_mod = full_s2;
		for (int j = 4; j >= 0; j--) begin
			if (red_mod >= (WHEEL_F << j)) begin
				red_mod = red_mod - (WHEEL_F << j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2 && rdy3) begin
			idx_s3 <= IDX_W'(red_mod);
		end
	end

	// split into segment and position
	logic [IDX_W:0] rem;
	logic [2:0]     seg_bits;

	always_comb begin
		rem      = (IDX_W+1)'(idx_s3);
		seg_bits = '0;
		if (rem >= SEG_X4) begin
			seg_bits[2] = 1'b1;
			rem         = rem - SEG_X4;
		end
		if (rem >= SEG_X2) begin
			seg_bits[1] = 1'b1;
			rem         = rem - SEG_X2;
		end
		if (rem >= SEG_X1) begin
			seg_bits[0] = 1'b1;
			rem         = rem - SEG_X1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s3 && rdy4) begin
			seg_s4 <= seg_t'(seg_bits);
			pos_s4 <= POS_W'(rem);
		end
	end

	// ramp lookup and channel select
	logic [COLOR_W-1:0] up_v, dn_v;
	logic [COLOR_W-1:0] red_c, green_c, blue_c;

	assign up_v = ramp_up[pos_s4];
	assign dn_v = ramp_dn[pos_s4];

	always_comb begin
		case (seg_s4)
			SEG_RED_YEL: begin
				red_c = CHAN_FULL; green_c = up_v;      blue_c = CHAN_OFF;
			end
			SEG_YEL_GRN: begin
				red_c = dn_v;      green_c = CHAN_FULL; blue_c = CHAN_OFF;
			end
			SEG_GRN_CYN: begin
				red_c = CHAN_OFF;  green_c = CHAN_FULL; blue_c = up_v;
			end
			SEG_CYN_BLU: begin
				red_c = CHAN_OFF;  green_c = dn_v;      blue_c = CHAN_FULL;
			end
			SEG_BLU_MAG: begin
				red_c = up_v;      green_c = CHAN_OFF;  blue_c = CHAN_FULL;
			end
			default: begin
				red_c = CHAN_FULL; green_c = CHAN_OFF;  blue_c = dn_v;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (vld_s4 && rdy5) begin
			red_s5   <= red_c;
			green_s5 <= green_c;
			blue_s5  <= blue_c;
		end
	end

	assign m_tvalid = vld_s5;
	assign m_tdata  = {ALPHA_OPAQUE, blue_s5, green_s5, red_s5};

	// checks
	a_idx_in_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (idx_s3 < IDX_W'(WHEEL)))
		else $error("wheel index out of range");

	a_split_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (({1'b0, pos_s4} < (POS_W+1)'(SEGMENT_STEPS))
			&& (seg_s4 != seg_t'(3'd6)) && (seg_s4 != seg_t'(3'd7))))
		else $error("segment split out of range");

	a_small_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && rdy2 && small_s1) |=> (full_s2 < FULL_W'(WHEEL)))
		else $error("direct wheel index too large");

	a_hue_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((red_s5 == CHAN_FULL) || (green_s5 == CHAN_FULL)
			|| (blue_s5 == CHAN_FULL)))
		else $error("no channel at full scale");

endmodule

[sv/ith_log2.sv]
// ----------------------------------------------------------------------------
// ith_log2
// pipelined fixed point log2: leading one detect and normalize, then one
// mantissa squaring per stage, one fraction bit per stage; a tag rides along
// ----------------------------------------------------------------------------
module ith_log2
	import ith_pkg::*;
#(
	parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF,
	parameter int TAG_W         = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [IN_W-1:0]          in_count,
	input  logic [TAG_W-1:0]         in_tag,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [EXP_W-1:0]         out_exp,
	output logic [LOG_FRAC_BITS-1:0] out_frac,
	output logic [TAG_W-1:0]         out_tag
);

	localparam int NST = LOG_FRAC_BITS;

	logic [NST:0]             vld_s;
	logic [NST:0]             rdy;
	logic [MANT_W-1:0]        mant_s [NST+1];
	logic [LOG_FRAC_BITS-1:0] frac_s [NST+1];
	logic [EXP_W-1:0]         exp_s  [NST+1];
	logic [TAG_W-1:0]         tag_s  [NST+1];

	logic [EXP_W-1:0]  exp_in;
	logic [MANT_W-1:0] mant_in;

	// leading one position and normalized mantissa
	always_comb begin
		exp_in = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (in_count[i]) begin
				exp_in = EXP_W'(i);
			end
		end
		mant_in = MANT_W'(in_count << (EXP_W'(IN_W - 1) - exp_in));
	end

	// ready chain, bubbles collapse
	genvar k;
	generate
		for (k = 0; k <= NST; k++) begin : g_rdy
			if (k == NST) begin : g_last
				assign rdy[k] = !vld_s[k] || out_ready;
			end else begin : g_mid
				assign rdy[k] = !vld_s[k] || rdy[k+1];
			end
		end
	endgenerate

	assign in_ready = rdy[0];

	// normalize stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy[0]) begin
			mant_s[0] <= mant_in;
			frac_s[0] <= '0;
			exp_s[0]  <= exp_in;
			tag_s[0]  <= in_tag;
		end
	end

	// squaring stages
	generate
		for (k = 1; k <= NST; k++) begin : g_sq
			logic [2*MANT_W-1:0] sq;
			logic                bit_hi;

			assign sq     = (2*MANT_W)'(mant_s[k-1]) * (2*MANT_W)'(mant_s[k-1]);
			assign bit_hi = sq[2*MANT_W-1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (vld_s[k-1] && rdy[k]) begin
					mant_s[k] <= bit_hi ? sq[2*MANT_W-1:MANT_W] : sq[2*MANT_W-2:MANT_W-1];
					frac_s[k] <= {frac_s[k-1][LOG_FRAC_BITS-2:0], bit_hi};
					exp_s[k]  <= exp_s[k-1];
					tag_s[k]  <= tag_s[k-1];
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[NST];
	assign out_exp   = exp_s[NST];
	assign out_frac  = frac_s[NST];
	assign out_tag   = tag_s[NST];

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// streams escape counts into the hue wheel palette block and compares every
// color that comes out against a bit-accurate predictor kept in a small
// scoreboard; both stream sides idle and stall at random
// ----------------------------------------------------------------------------
module tb_top;
	import ith_pkg::*;

	localparam int STEPS         = SEGMENT_STEPS_DEF;
	localparam int FRAC          = LOG_FRAC_BITS_DEF;
	localparam int WHEEL         = 6 * STEPS;
	localparam int SETTLE_CYCLES = FRAC + 16;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 800;

	// one result word, alpha in the top byte
	typedef struct packed {
		logic [COLOR_W-1:0] alpha;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} hue_rgba_t;

	// expected colors in request order, plus the color predictor
	class hue_scoreboard;
		hue_rgba_t colors_due[$];
		int        errors;

		function new();
			errors = 0;
		endfunction

		// log2 with FRAC fraction bits by repeated squaring of the mantissa
		function logic [63:0] log2_fixed(logic [63:0] n);
			logic [63:0] mant;
			logic [63:0] sq;
			logic [63:0] frac;
			logic [63:0] top;
			top  = 0;
			frac = 0;
			if (n == 0) begin
				return 0;
			end
			for (int b = 0; b <= 30; b++) begin
				if (n[b]) begin
					top = b;
				end
			end
			mant = n << (30 - top);
			for (int k = 0; k < FRAC; k++) begin
				sq   = mant * mant;
				frac = frac << 1;
				if (sq >= (64'd1 << 61)) begin
					frac = frac | 64'd1;
					mant = sq >> 31;
				end else begin
					mant = sq >> 30;
				end
			end
			return (top << FRAC) + frac;
		endfunction

		function hue_rgba_t color_of(logic [IN_W-1:0] count);
			logic [63:0] n;
			logic [63:0] idx;
			logic [63:0] diff;
			logic [63:0] ln;
			logic [63:0] lw;
			logic [63:0] s;
			logic [63:0] p;
			logic [63:0] num;
			logic [63:0] den;
			logic [63:0] up;
			logic [63:0] down;
			logic [63:0] seg_num;
			seg_t        seg;
			hue_rgba_t   c;
			n = 64'(count);
			s = 64'(STEPS);
			if (n < WHEEL) begin
				idx = n;
			end else begin
				ln   = log2_fixed(n);
				lw   = log2_fixed(64'(WHEEL));
				diff = (ln > lw) ? ln - lw : 64'd0;
				idx  = (64'(WHEEL) * diff) >> FRAC;
			end
			idx     = idx % WHEEL;
			seg_num = idx / s;
			seg     = seg_t'(seg_num[2:0]);
			p       = idx % s;
			// smootherstep ramp, exact rational then truncated
			den = s * s * s * s * s;
			num = p * p * p * (10 * s * s + 6 * p * p - 15 * p * s);
			if (num > den) begin
				num = den;
			end
			up   = (255 * num) / den;
			down = (255 * (den - num)) / den;
			case (seg)
				SEG_RED_YEL: begin
					c.red = CHAN_FULL; c.green = up[7:0]; c.blue = CHAN_OFF;
				end
				SEG_YEL_GRN: begin
					c.red = down[7:0]; c.green = CHAN_FULL; c.blue = CHAN_OFF;
				end
				SEG_GRN_CYN: begin
					c.red = CHAN_OFF; c.green = CHAN_FULL; c.blue = up[7:0];
				end
				SEG_CYN_BLU: begin
					c.red = CHAN_OFF; c.green = down[7:0]; c.blue = CHAN_FULL;
				end
				SEG_BLU_MAG: begin
					c.red = up[7:0]; c.green = CHAN_OFF; c.blue = CHAN_FULL;
				end
				default: begin
					c.red = CHAN_FULL; c.green = CHAN_OFF; c.blue = down[7:0];
				end
			endcase
			c.alpha = ALPHA_OPAQUE;
			return c;
		endfunction

		function void note_request(logic [31:0] word);
			colors_due.push_back(color_of(word[IN_W-1:0]));
		endfunction

		function void check_color(logic [31:0] word);
			hue_rgba_t got;
			hue_rgba_t want;
			got = hue_rgba_t'(word);
			if (colors_due.size() == 0) begin
				$error("color result 0x%08h with no request outstanding", word);
				errors++;
				return;
			end
			want = colors_due.pop_front();
			if (got.red !== want.red) begin
				$error("red mismatch: expected %0d, actual %0d", want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$error("green mismatch: expected %0d, actual %0d", want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$error("blue mismatch: expected %0d, actual %0d", want.blue, got.blue);
				errors++;
			end
			if (got.alpha !== want.alpha) begin
				$error("alpha mismatch: expected %0d, actual %0d", want.alpha, got.alpha);
				errors++;
			end
		endfunction

		function int pending();
			return colors_due.size();
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // [30:0] iteration_count, [31] zero fill
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha

	// no idling on either side while set
	logic        steady   = 1'b0;

	hue_scoreboard sb = new();

	iteration_to_hue_color dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// idle length: mostly short, now and then long
	function automatic int idle_cycles();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 40) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// watch both handshakes at every edge, request side first
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_request(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				sb.check_color(m_tdata);
			end
		end
	end

	// result side backpressure
	initial begin
		int stall;
		forever begin
			stall = idle_cycles();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// run limit
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// one request, then a random gap
	task automatic send_count(input logic [31:0] word);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		gap = idle_cycles();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every expected color has come back
	task automatic drain_colors();
		if (s_tvalid) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// random count: small direct indexes or a random log2 octave
	function automatic logic [31:0] random_count();
		logic [31:0] word;
		int          k;
		int          roll;
		roll = $urandom_range(0, 9);
		if (roll < 3) begin
			word = $urandom_range(0, WHEEL - 1);
		end else begin
			k    = $urandom_range(1, IN_W);
			word = ($urandom & ((32'd1 << k) - 1)) | (32'd1 << (k - 1));
		end
		// the fill bit above the count is ignored by the block
		if ($urandom_range(0, 19) == 0) begin
			word[31] = 1'b1;
		end
		return word;
	endfunction

	initial begin
		logic [31:0] directed[$];
		directed = '{
			32'd0, 32'd1, 32'd59, 32'd60, 32'd61, 32'd119, 32'd120, 32'd180,
			32'd240, 32'd300, 32'd359, 32'd360, 32'd361, 32'd720, 32'd1000,
			32'd1023, 32'd1024, 32'd65535, 32'h0010_0000, 32'h3FFF_FFFF,
			32'h4000_0000, 32'h7FFF_FFFF, 32'h2AAA_AAAA, 32'h5555_5555,
			32'h8000_0005
		};

		// reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed counts: zero, segment edges, wheel edge, octave edges, full scale
		foreach (directed[i]) begin
			send_count(directed[i]);
		end
		drain_colors();

		// random counts, with a back to back stretch and a full drain midway
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 150 && i < 250);
			if (i == 400) begin
				drain_colors();
			end
			send_count(random_count());
		end
		steady = 1'b0;

		// let the pipeline empty
		drain_colors();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
